### src/rwcp_pkg.sv
// ============================================================================
// rwcp_pkg - shared definitions for the RIFF/WAVE chunk parser
// Role and chunk kind codes, tag constants, header pattern, result record.
// ============================================================================
package rwcp_pkg;

    localparam int SizeBytes = 4;
    localparam int TagLen    = 4;
    localparam int HeaderLen = 12;

    localparam logic [2:0] ROLE_HEADER  = 3'd0;
    localparam logic [2:0] ROLE_TAG     = 3'd1;
    localparam logic [2:0] ROLE_SIZE    = 3'd2;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
    localparam logic [2:0] ROLE_IGNORED = 3'd4;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_FMT     = 3'd1;
    localparam logic [2:0] KIND_DATA    = 3'd2;
    localparam logic [2:0] KIND_FACT    = 3'd3;
    localparam logic [2:0] KIND_LIST    = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN = 3'd5;

    localparam logic [31:0] FOURCC_FMT  = 32'h666D_7420; // "fmt "
    localparam logic [31:0] FOURCC_DATA = 32'h6461_7461; // "data"
    localparam logic [31:0] FOURCC_FACT = 32'h6661_6374; // "fact"
    localparam logic [31:0] FOURCC_LIST = 32'h4C49_5354; // "LIST"

    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_V = 8'h56;
    localparam logic [7:0] CH_E = 8'h45;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [2:0]  role;
        logic [2:0]  chunk_kind;
        logic [31:0] payload_offset;
        logic        chunk_end;
        logic        header_ok;
        logic        last_out;
    } result_t;

    function automatic logic [2:0] classify_tag(input logic [31:0] tag);
        logic [2:0] kind;
        unique case (tag)
            FOURCC_FMT:  kind = KIND_FMT;
            FOURCC_DATA: kind = KIND_DATA;
            FOURCC_FACT: kind = KIND_FACT;
            FOURCC_LIST: kind = KIND_LIST;
            default:     kind = KIND_UNKNOWN;
        endcase
        return kind;
    endfunction

    // expected header byte; the RIFF size bytes 4-7 are not compared
    function automatic logic [7:0] header_byte(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = CH_R;
            4'd1:    ch = CH_I;
            4'd2:    ch = CH_F;
            4'd3:    ch = CH_F;
            4'd8:    ch = CH_W;
            4'd9:    ch = CH_A;
            4'd10:   ch = CH_V;
            4'd11:   ch = CH_E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic header_checked(input logic [3:0] idx);
        return (idx < 4'd4) || (idx >= 4'd8);
    endfunction

endpackage

### src/riff_wave_chunk_parser_unit.sv
// ============================================================================
// riff_wave_chunk_parser_unit - RIFF/WAVE byte stream chunk parser
// Checks the RIFF/WAVE header, walks tag/size/payload chunks and labels
// every byte with its role, chunk kind and payload offset.
// ============================================================================
//
//  channel | direction | ports                          | moves
//  --------+-----------+--------------------------------+-------------------
//  s_      | in        | s_valid s_ready s_data_byte    | one file byte per
//          |           | s_last_byte                    | request
//  m_      | out       | m_valid m_ready m_byte_value   | one labelled byte
//          |           | m_role m_chunk_kind ...        | per request
//
//  One byte per clock while m_ready holds; a request passes from input to
//  output through the input register, then labelling logic into the result register.
//  The walker state updates as a byte moves from the input register into the
//  result register, so consecutive bytes follow back to back.
//  Reset: synchronous, active low; walker starts in the header phase.
//  A stalled m_ side holds the result register; the input register keeps
//  taking a request as long as its byte can move on in the same cycle.
//
module riff_wave_chunk_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_value,
    output logic [2:0]  m_role,
    output logic [2:0]  m_chunk_kind,
    output logic [31:0] m_payload_offset,
    output logic        m_chunk_end,
    output logic        m_header_ok,
    output logic        m_last_out
);
    import rwcp_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // result register
    logic       out_valid_reg;
    result_t    out_result_reg;

    result_t    walk_result;
    logic       advance;

    // byte moves from input register to result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    rwcp_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (walk_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        // payload, no reset needed
        if (s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
        if (advance) begin
            out_result_reg <= walk_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_byte_value     = out_result_reg.byte_value;
    assign m_role           = out_result_reg.role;
    assign m_chunk_kind     = out_result_reg.chunk_kind;
    assign m_payload_offset = out_result_reg.payload_offset;
    assign m_chunk_end      = out_result_reg.chunk_end;
    assign m_header_ok      = out_result_reg.header_ok;
    assign m_last_out       = out_result_reg.last_out;

`ifndef SYNTHESIS
    a_payload_known_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_role == ROLE_PAYLOAD) |->
            (m_chunk_kind != KIND_NONE && m_chunk_kind != KIND_UNKNOWN))
        else $error("payload byte without a known chunk kind");

    a_offset_only_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_role != ROLE_PAYLOAD) |-> (m_payload_offset == 32'd0))
        else $error("nonzero offset outside payload");

    a_end_role: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_chunk_end) |-> (m_role == ROLE_PAYLOAD || m_role == ROLE_SIZE))
        else $error("chunk end on a byte that is neither size nor payload");

    a_ignored_good_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_role == ROLE_IGNORED && m_header_ok) |->
            (m_chunk_kind == KIND_UNKNOWN))
        else $error("ignored byte after good header without unknown tag");
`endif

endmodule

### src/rwcp_walker.sv
// ============================================================================
// rwcp_walker - chunk walker state and per-byte labelling
// Labels the byte on its input combinationally; state advances on step.
// ============================================================================
module rwcp_walker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output rwcp_pkg::result_t result
);
    import rwcp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TAG,
        PH_SIZE,
        PH_PAYLOAD,
        PH_IGNORED
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  fc_reg, fc_next;
    logic [23:0] tag_reg, tag_next;      // only the last three tag bytes matter
    logic [31:0] size_reg, size_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] pos_reg, pos_next;
    logic [2:0]  kind_reg, kind_next;
    logic        good_reg, good_next;

    always_comb begin
        logic [3:0]  idx;
        logic [3:0]  fc_inc;
        logic [31:0] tag_full;
        logic [31:0] size_acc;
        logic [31:0] left_dec;
        logic [2:0]  kind_new;
        logic [2:0]  role;
        logic [31:0] offset;
        logic        chunk_end;

        phase_next = phase_reg;
        fc_next    = fc_reg;
        tag_next   = tag_reg;
        size_next  = size_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        good_next  = good_reg;
        role       = ROLE_IGNORED;
        offset     = '0;
        chunk_end  = 1'b0;
        idx        = (fc_reg >= 4'(HeaderLen)) ? 4'(HeaderLen - 1) : fc_reg;
        fc_inc     = fc_reg + 4'd1;
        tag_full   = {tag_reg, data_byte};
        kind_new   = classify_tag(tag_full);
        size_acc   = size_reg | (32'(data_byte) << {fc_reg[1:0], 3'b000});
        left_dec   = left_reg - 32'd1;

        unique case (phase_reg)
            PH_HEADER: begin
                role = ROLE_HEADER;
                if (header_checked(idx) && (data_byte != header_byte(idx))) begin
                    good_next = 1'b0;
                end
                if (idx == 4'(HeaderLen - 1)) begin
                    phase_next = good_next ? PH_TAG : PH_IGNORED;
                    fc_next    = '0;
                end else begin
                    fc_next = idx + 4'd1;
                end
            end
            PH_TAG: begin
                role     = ROLE_TAG;
                tag_next = tag_full[23:0];
                fc_next  = fc_inc;
                if (fc_inc >= 4'(TagLen)) begin
                    fc_next   = '0;
                    kind_next = kind_new;
                    if (kind_new == KIND_UNKNOWN) begin
                        phase_next = PH_IGNORED;
                    end else begin
                        phase_next = PH_SIZE;
                        size_next  = '0;
                    end
                end
            end
            PH_SIZE: begin
                role      = ROLE_SIZE;
                size_next = size_acc;
                fc_next   = fc_inc;
                if (fc_inc >= 4'(SizeBytes)) begin
                    fc_next   = '0;
                    pos_next  = '0;
                    left_next = size_acc;
                    tag_next  = '0;
                    if (size_acc == 32'd0) begin
                        chunk_end  = 1'b1;
                        phase_next = PH_TAG;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                role      = ROLE_PAYLOAD;
                offset    = pos_reg;
                pos_next  = pos_reg + 32'd1;
                left_next = left_dec;
                if (left_dec == 32'd0) begin
                    chunk_end  = 1'b1;
                    phase_next = PH_TAG;
                    fc_next    = '0;
                    tag_next   = '0;
                end
            end
            default: begin
                role = ROLE_IGNORED;
            end
        endcase

        result.byte_value     = data_byte;
        result.role           = role;
        result.chunk_kind     = kind_next;
        result.payload_offset = offset;
        result.chunk_end      = chunk_end;
        result.header_ok      = (phase_next != PH_HEADER) && good_next;
        result.last_out       = last_byte;

        // end of file: walker back to its reset state for the next file
        if (last_byte) begin
            phase_next = PH_HEADER;
            fc_next    = '0;
            tag_next   = '0;
            size_next  = '0;
            left_next  = '0;
            pos_next   = '0;
            kind_next  = KIND_NONE;
            good_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            fc_reg    <= '0;
            tag_reg   <= '0;
            size_reg  <= '0;
            left_reg  <= '0;
            pos_reg   <= '0;
            kind_reg  <= KIND_NONE;
            good_reg  <= 1'b1;
        end else if (step) begin
            phase_reg <= phase_next;
            fc_reg    <= fc_next;
            tag_reg   <= tag_next;
            size_reg  <= size_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            kind_reg  <= kind_next;
            good_reg  <= good_next;
        end
    end

`ifndef SYNTHESIS
    a_payload_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (left_reg != 32'd0))
        else $error("payload phase with no bytes left");

    a_header_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEADER) |-> (fc_reg < 4'(HeaderLen)))
        else $error("header byte count out of range");

    a_field_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TAG || phase_reg == PH_SIZE) |-> (fc_reg < 4'(TagLen)))
        else $error("tag/size byte count out of range");
`endif

endmodule
